[hw/rtl/lda_pkg.sv]
package lda_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LENS_RADIUS = 1'b0,
      CSR_LENS_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [5:0] LENS_RADIUS_RESET = 6'd40;
   localparam logic [7:0] LENS_HEIGHT_RESET = 8'd18;

   localparam int RAD_WIDTH = 12;
   localparam int QUO_WIDTH = 15;

   typedef struct packed {
      logic [6:0] win_x;
      logic [6:0] win_y;
      logic [8:0] lens_left;
      logic [7:0] lens_top;
   } req_type;

   typedef struct packed {
      logic [8:0] dest_col;
      logic [8:0] dest_row;
      logic [8:0] src_col;
      logic [7:0] src_row;
      logic       copy;
   } rsp_type;

   typedef struct packed {
      logic              in_lens;
      logic signed [7:0] ux;
      logic signed [7:0] uy;
      logic [7:0]        height;
      logic [9:0]        sum_x;
      logic [8:0]        sum_y;
   } side_type;

endpackage

[hw/rtl/lda_front.sv]
module lda_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lda_pkg::req_type   in_data,
   input  logic [5:0]         radius,
   input  logic [7:0]         height,
   output logic               out_valid,
   output lda_pkg::side_type  out_side,
   output logic [lda_pkg::RAD_WIDTH-1:0] out_rad
);
   import lda_pkg::*;

   logic signed [7:0]  ux_in, uy_in;
   logic signed [15:0] sqx, sqy;
   logic [14:0]        r2_in;
   logic [5:0]         rm1;
   logic [11:0]        rr_in, lim_in;

   logic               s1_valid_ff;
   logic signed [7:0]  s1_ux_ff, s1_uy_ff;
   logic [14:0]        s1_r2_ff;
   logic [11:0]        s1_rr_ff, s1_lim_ff;
   logic [7:0]         s1_h_ff;
   logic [9:0]         s1_sx_ff;
   logic [8:0]         s1_sy_ff;

   logic               valid_ff;
   side_type           side_ff;
   logic [RAD_WIDTH-1:0] rad_ff;

   always_comb begin
      ux_in  = $signed({1'b0, in_data.win_x}) - $signed({2'b00, radius});
      uy_in  = $signed({1'b0, in_data.win_y}) - $signed({2'b00, radius});
      sqx    = ux_in * ux_in;
      sqy    = uy_in * uy_in;
      r2_in  = 15'($unsigned(sqx)) + 15'($unsigned(sqy));
      rm1    = radius - 6'd1;
      rr_in  = 12'(radius) * 12'(radius);
      lim_in = (radius >= 6'd2) ? (12'(rm1) * 12'(rm1)) : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         valid_ff    <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ux_ff  <= ux_in;
         s1_uy_ff  <= uy_in;
         s1_r2_ff  <= r2_in;
         s1_rr_ff  <= rr_in;
         s1_lim_ff <= lim_in;
         s1_h_ff   <= height;
         s1_sx_ff  <= 10'(in_data.win_x) + 10'(in_data.lens_left);
         s1_sy_ff  <= 9'(in_data.win_y) + 9'(in_data.lens_top);

         side_ff.in_lens <= (s1_r2_ff < 15'(s1_lim_ff));
         side_ff.ux      <= s1_ux_ff;
         side_ff.uy      <= s1_uy_ff;
         side_ff.height  <= s1_h_ff;
         side_ff.sum_x   <= s1_sx_ff;
         side_ff.sum_y   <= s1_sy_ff;
         rad_ff          <= s1_rr_ff - s1_r2_ff[11:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rad   = rad_ff;

endmodule

[hw/rtl/lda_sqrt.sv]
module lda_sqrt #(
   parameter int Z_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lda_pkg::side_type  in_side,
   input  logic [lda_pkg::RAD_WIDTH-1:0] in_rad,
   output logic               out_valid,
   output lda_pkg::side_type  out_side,
   output logic [lda_pkg::RAD_WIDTH/2+Z_FRAC_BITS-1:0] out_z
);
   import lda_pkg::*;

   localparam int VW = RAD_WIDTH + 2 * Z_FRAC_BITS;
   localparam int ZW = RAD_WIDTH / 2 + Z_FRAC_BITS;

   logic [VW-1:0] rem_w   [0:ZW];
   logic [ZW-1:0] q_w     [0:ZW];
   side_type      side_w  [0:ZW];
   logic          valid_w [0:ZW];

   assign rem_w[0]   = VW'(in_rad) << (2 * Z_FRAC_BITS);
   assign q_w[0]     = '0;
   assign side_w[0]  = in_side;
   assign valid_w[0] = in_valid;

   for (genvar k = 0; k < ZW; k++) begin : g_stage
      localparam int I = ZW - 1 - k;
      logic [VW:0]   trial;
      logic          take;
      logic [ZW-1:0] q_ff;
      side_type      side_ff;
      logic          valid_ff;

      assign trial = ((VW + 1)'(q_w[k]) << (I + 1)) | ((VW + 1)'(1) << (2 * I));
      assign take  = ({1'b0, rem_w[k]} >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff    <= take ? (q_w[k] | (ZW'(1) << I)) : q_w[k];
            side_ff <= side_w[k];
         end
      end

      if (k < ZW - 1) begin : g_rem
         logic [VW-1:0] rem_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff <= take ? VW'({1'b0, rem_w[k]} - trial) : rem_w[k];
            end
         end
         assign rem_w[k+1] = rem_ff;
      end else begin : g_last
         assign rem_w[k+1] = '0;
      end

      assign q_w[k+1]     = q_ff;
      assign side_w[k+1]  = side_ff;
      assign valid_w[k+1] = valid_ff;
   end

   assign out_valid = valid_w[ZW];
   assign out_side  = side_w[ZW];
   assign out_z     = q_w[ZW];

endmodule

[hw/rtl/lda_div.sv]
module lda_div #(
   parameter int Z_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lda_pkg::side_type  in_side,
   input  logic [lda_pkg::RAD_WIDTH/2+Z_FRAC_BITS-1:0] in_z,
   output logic               out_valid,
   output lda_pkg::side_type  out_side,
   output logic [lda_pkg::QUO_WIDTH-1:0] out_qx,
   output logic [lda_pkg::QUO_WIDTH-1:0] out_qy,
   output logic               out_negx,
   output logic               out_negy
);
   import lda_pkg::*;

   localparam int ZW = RAD_WIDTH / 2 + Z_FRAC_BITS;
   localparam int DW = 9 + Z_FRAC_BITS;
   localparam int PW = DW + 7;
   localparam int CW = ZW + QUO_WIDTH;

   logic signed [DW-1:0]   diff;
   logic signed [DW+7:0]   px, py;
   logic [PW-1:0]          mx_in, my_in;

   logic                   p_valid_ff;
   side_type               p_side_ff;
   logic [ZW-1:0]          p_z_ff;
   logic [PW-1:0]          p_mx_ff, p_my_ff;
   logic                   p_negx_ff, p_negy_ff;

   always_comb begin
      diff  = DW'($signed({1'b0, DW'(in_side.height) << Z_FRAC_BITS})
                  - $signed({1'b0, in_z}));
      px    = diff * in_side.ux;
      py    = diff * in_side.uy;
      mx_in = px[DW+7] ? PW'(-px) : PW'(px);
      my_in = py[DW+7] ? PW'(-py) : PW'(py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_side_ff <= in_side;
         p_z_ff    <= in_z;
         p_mx_ff   <= mx_in;
         p_my_ff   <= my_in;
         p_negx_ff <= px[DW+7];
         p_negy_ff <= py[DW+7];
      end
   end

   logic [PW-1:0]        rx_w    [0:QUO_WIDTH];
   logic [PW-1:0]        ry_w    [0:QUO_WIDTH];
   logic [QUO_WIDTH-1:0] qx_w    [0:QUO_WIDTH];
   logic [QUO_WIDTH-1:0] qy_w    [0:QUO_WIDTH];
   logic [ZW-1:0]        z_w     [0:QUO_WIDTH];
   side_type             side_w  [0:QUO_WIDTH];
   logic                 nx_w    [0:QUO_WIDTH];
   logic                 ny_w    [0:QUO_WIDTH];
   logic                 valid_w [0:QUO_WIDTH];

   assign rx_w[0]    = p_mx_ff;
   assign ry_w[0]    = p_my_ff;
   assign qx_w[0]    = '0;
   assign qy_w[0]    = '0;
   assign z_w[0]     = p_z_ff;
   assign side_w[0]  = p_side_ff;
   assign nx_w[0]    = p_negx_ff;
   assign ny_w[0]    = p_negy_ff;
   assign valid_w[0] = p_valid_ff;

   for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_stage
      localparam int I = QUO_WIDTH - 1 - k;
      logic [CW-1:0]        dsh;
      logic                 tx, ty;
      logic [PW-1:0]        rx_ff, ry_ff;
      logic [QUO_WIDTH-1:0] qx_ff, qy_ff;
      logic [ZW-1:0]        z_ff;
      side_type             side_ff;
      logic                 nx_ff, ny_ff, valid_ff;

      assign dsh = CW'(z_w[k]) << I;
      assign tx  = (CW'(rx_w[k]) >= dsh);
      assign ty  = (CW'(ry_w[k]) >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff   <= tx ? PW'(CW'(rx_w[k]) - dsh) : rx_w[k];
            ry_ff   <= ty ? PW'(CW'(ry_w[k]) - dsh) : ry_w[k];
            qx_ff   <= tx ? (qx_w[k] | (QUO_WIDTH'(1) << I)) : qx_w[k];
            qy_ff   <= ty ? (qy_w[k] | (QUO_WIDTH'(1) << I)) : qy_w[k];
            z_ff    <= z_w[k];
            side_ff <= side_w[k];
            nx_ff   <= nx_w[k];
            ny_ff   <= ny_w[k];
         end
      end

      assign rx_w[k+1]    = rx_ff;
      assign ry_w[k+1]    = ry_ff;
      assign qx_w[k+1]    = qx_ff;
      assign qy_w[k+1]    = qy_ff;
      assign z_w[k+1]     = z_ff;
      assign side_w[k+1]  = side_ff;
      assign nx_w[k+1]    = nx_ff;
      assign ny_w[k+1]    = ny_ff;
      assign valid_w[k+1] = valid_ff;
   end

   assign out_valid = valid_w[QUO_WIDTH];
   assign out_side  = side_w[QUO_WIDTH];
   assign out_qx    = qx_w[QUO_WIDTH];
   assign out_qy    = qy_w[QUO_WIDTH];
   assign out_negx  = nx_w[QUO_WIDTH];
   assign out_negy  = ny_w[QUO_WIDTH];

endmodule

[hw/rtl/lens_distortion_address_gen.sv]
// Lens distortion address generator. Takes one lens-window pixel per clock, except while stalled,
// and returns its destination address, the magnified source address and a copy flag, in order,
// one result per transaction. Pipeline: two front stages for the offsets and circle test,
// 6 + Z_FRAC_BITS square-root stages (one result bit each), one multiply stage, 15 divider
// stages (one quotient bit each, both axes in parallel) and the output register. A stall on
// rsp_stall while a result waits holds the whole pipeline; otherwise one transaction enters
// and one leaves every cycle. Write lens_radius and lens_height only while idle.
module lens_distortion_address_gen #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 200,
   parameter int Z_FRAC_BITS   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lda_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lda_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [lda_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lda_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import lda_pkg::*;

   localparam int ZW = RAD_WIDTH / 2 + Z_FRAC_BITS;
   localparam int CW = QUO_WIDTH + 3;

   logic [5:0]           radius_ff;
   logic [7:0]           height_ff;
   logic                 adv;

   logic                 f_valid;
   side_type             f_side;
   logic [RAD_WIDTH-1:0] f_rad;
   logic                 s_valid;
   side_type             s_side;
   logic [ZW-1:0]        s_z;
   logic                 d_valid;
   side_type             d_side;
   logic [QUO_WIDTH-1:0] d_qx, d_qy;
   logic                 d_negx, d_negy;

   logic signed [CW-1:0] sx, sy, col, row;
   logic                 hit;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= LENS_RADIUS_RESET;
         height_ff <= LENS_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LENS_RADIUS: radius_ff <= csr_wdata[5:0];
            CSR_LENS_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   lda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .radius    (radius_ff),
      .height    (height_ff),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_rad   (f_rad)
   );

   lda_sqrt #(.Z_FRAC_BITS(Z_FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_rad    (f_rad),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_z     (s_z)
   );

   lda_div #(.Z_FRAC_BITS(Z_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_valid),
      .in_side   (s_side),
      .in_z      (s_z),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_qx    (d_qx),
      .out_qy    (d_qy),
      .out_negx  (d_negx),
      .out_negy  (d_negy)
   );

   always_comb begin
      sx  = d_negx ? -$signed(CW'(d_qx)) : $signed(CW'(d_qx));
      sy  = d_negy ? -$signed(CW'(d_qy)) : $signed(CW'(d_qy));
      col = $signed(CW'(d_side.sum_x)) + sx;
      row = $signed(CW'(d_side.sum_y)) + sy;
      hit = d_side.in_lens
         && (col >= $signed(CW'(1))) && (col < $signed(CW'(SCREEN_WIDTH)))
         && (row >= $signed(CW'(1))) && (row < $signed(CW'(SCREEN_HEIGHT)));
      rsp_in.dest_col = d_side.sum_x[8:0];
      rsp_in.dest_row = d_side.sum_y;
      rsp_in.src_col  = hit ? col[8:0] : 9'd0;
      rsp_in.src_row  = hit ? row[7:0] : 8'd0;
      rsp_in.copy     = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sim/lens_distortion_address_gen_checker.sv]
module lens_distortion_address_gen_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  lda_pkg::req_type     req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lda_pkg::rsp_type     rsp_data,
   input  logic                 csr_wr_en,
   input  logic [lda_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lda_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);
   import lda_pkg::*;

   logic [5:0] radius;
   logic [7:0] height;
   rsp_type    expected_addrs[$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v = v - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type map_pixel(req_type t, logic [5:0] rad, logic [7:0] hgt);
      rsp_type res;
      longint wx, wy, r, ux, uy, r2, zq, diff, sx, sy, c, rw;
      wx = t.win_x;
      wy = t.win_y;
      r = rad;
      ux = wx - r;
      uy = wy - r;
      r2 = ux * ux + uy * uy;
      res = '0;
      res.dest_col = 9'(wx + t.lens_left);
      res.dest_row = 9'(wy + t.lens_top);
      if (r >= 2 && r2 < (r - 1) * (r - 1)) begin
         zq = longint'(int_sqrt(longint'(r * r - r2) << 16));
         if (zq > 0) begin
            diff = (longint'(hgt) << 8) - zq;
            sx = (diff * ux) / zq;
            sy = (diff * uy) / zq;
            c = wx + t.lens_left + sx;
            rw = wy + t.lens_top + sy;
            if (rw >= 1 && rw < 200 && c >= 1 && c < 320) begin
               res.copy = 1'b1;
               res.src_col = 9'(c);
               res.src_row = 8'(rw);
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         radius <= LENS_RADIUS_RESET;
         height <= LENS_HEIGHT_RESET;
         expected_addrs.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_LENS_RADIUS) radius <= csr_wdata[5:0];
            else if (csr_index == CSR_LENS_HEIGHT) height <= csr_wdata;
         end
         if (req_valid && !req_stall)
            expected_addrs.push_back(map_pixel(req_data, radius, height));
         if (rsp_valid && !rsp_stall) begin
            if (expected_addrs.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected transaction: %p", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_addrs.pop_front();
               if (want !== rsp_data) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count <= expected_addrs.size();
   end
endmodule

[sim/lens_distortion_address_gen_tb.sv]
module lens_distortion_address_gen_tb;
   import lda_pkg::*;

   localparam int LATENCY = 33;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   int mismatch_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycles = 0;

   always #5 clock = ~clock;

   lens_distortion_address_gen uut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   lens_distortion_address_gen_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_wr_en, .csr_index, .csr_wdata, .mismatch_count, .pending_count
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_pixel(req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type random_pixel(logic [5:0] rad);
      req_type t;
      t.lens_left = 9'($urandom_range(319));
      t.lens_top = 8'($urandom_range(199));
      if ($urandom_range(9) == 0) begin
         t.win_x = 7'($urandom);
         t.win_y = 7'($urandom);
         t.lens_left = 9'($urandom);
         t.lens_top = 8'($urandom);
      end else begin
         t.win_x = 7'($urandom_range(2 * rad));
         t.win_y = 7'($urandom_range(2 * rad));
      end
      return t;
   endfunction

   task automatic run_phase(int count, logic [5:0] rad, logic [7:0] hgt);
      drain();
      write_reg(CSR_LENS_RADIUS, {2'b00, rad});
      write_reg(CSR_LENS_HEIGHT, hgt);
      for (int i = 0; i < count; i++) send_pixel(random_pixel(rad));
   endtask

   initial begin
      req_type t;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9;
      recv_idle_pct = 58;
      // directed corners at reset settings
      t = '{win_x: 7'd40, win_y: 7'd40, lens_left: 9'd100, lens_top: 8'd50};
      send_pixel(t);
      t = '{win_x: 7'd0, win_y: 7'd0, lens_left: 9'd0, lens_top: 8'd0};
      send_pixel(t);
      t = '{win_x: 7'd127, win_y: 7'd127, lens_left: 9'd511, lens_top: 8'd255};
      send_pixel(t);
      t = '{win_x: 7'd79, win_y: 7'd40, lens_left: 9'd319, lens_top: 8'd199};
      send_pixel(t);
      t = '{win_x: 7'd20, win_y: 7'd30, lens_left: 9'd0, lens_top: 8'd0};
      send_pixel(t);
      t = '{win_x: 7'd60, win_y: 7'd50, lens_left: 9'd300, lens_top: 8'd190};
      send_pixel(t);
      t = '{win_x: 7'd41, win_y: 7'd2, lens_left: 9'd10, lens_top: 8'd5};
      send_pixel(t);
      t = '{win_x: 7'd42, win_y: 7'd42, lens_left: 9'd140, lens_top: 8'd80};
      send_pixel(t);
      // hold until every expected transaction has come back
      drain();
      run_phase(20, 6'd1, 8'd255);
      run_phase(20, 6'd2, 8'd0);
      run_phase(150, 6'd63, 8'd255);
      run_phase(150, 6'd63, 8'd0);
      send_idle_pct = 58;
      recv_idle_pct = 9;
      run_phase(200, 6'd10, 8'd40);
      run_phase(150, 6'd25, 8'd128);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(200, 6'(2 + $urandom_range(61)), 8'($urandom));
      run_phase(100, 6'd40, 8'd18);
      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[sim.f]
hw/rtl/lda_pkg.sv
hw/rtl/lda_front.sv
hw/rtl/lda_sqrt.sv
hw/rtl/lda_div.sv
hw/rtl/lens_distortion_address_gen.sv
sim/lens_distortion_address_gen_checker.sv
sim/lens_distortion_address_gen_tb.sv
